FILE: hdl/scanint_pkg.sv
// Shared constants, types and enums of the scanline interpolator.
// No dependencies; every other file but scanint_ram uses this package.
package scanint_pkg;

	localparam int LINE_WIDTH = 320;
	localparam int FRAME_ROWS = 360;
	localparam int SRC_ROWS   = FRAME_ROWS / 2;

	localparam int COL_W   = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
	localparam int ROW_W   = (SRC_ROWS > 1) ? $clog2(SRC_ROWS) : 1;
	localparam int COORD_W = 9;
	localparam int COLOR_W = 24;
	localparam int ARGB_W  = 32;
	localparam int ALPHA_W = 8;

	localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 8'hb0;

	// Source pixel as it waits in stage 1 for its result words
	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [COLOR_W-1:0] color;
	} item_t;

	// Progress through the result words of the item in stage 1
	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SOURCE,
		PH_FINAL
	} phase_t;

	// Kind of result word being issued
	typedef enum logic [1:0] {
		RK_INTERP,
		RK_SOURCE,
		RK_FINAL
	} res_kind_t;

endpackage

FILE: hdl/scanint_if.sv
// Valid/ready channels of the scanline interpolator: source pixels in, ARGB words out.
// Depends on scanint_pkg for the payload widths.
interface scanint_pix_if;
	logic                            valid;
	logic                            ready;
	logic                            frame_start;
	logic [scanint_pkg::COLOR_W-1:0] color;

	modport source (output valid, frame_start, color, input ready);
	modport sink   (input valid, frame_start, color, output ready);
endinterface

interface scanint_res_if;
	logic                            valid;
	logic                            ready;
	logic [scanint_pkg::COORD_W-1:0] out_row;
	logic [scanint_pkg::COORD_W-1:0] out_col;
	logic [scanint_pkg::ARGB_W-1:0]  argb;
	logic                            last;

	modport source (output valid, out_row, out_col, argb, last, input ready);
	modport sink   (input valid, out_row, out_col, argb, last, output ready);
endinterface

FILE: hdl/scanint_ram.sv
// Generic single-clock RAM, one write and one read port, registered read-first output.
// No dependencies.
module scanint_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 320
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read and a write of one entry in a cycle returns the old data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

FILE: hdl/scanint_front.sv
// Input side: column/row counters, line buffer addressing and the stage 1 item register.
// Depends on scanint_pkg and scanint_if.
module scanint_front (
	input  logic                 clk,
	input  logic                 arst_n,
	scanint_pix_if.sink          pix,
	input  logic                 take,
	output logic                 valid_s1,
	output scanint_pkg::item_t   item_s1,
	output logic                 ram_we,
	output logic                 ram_re,
	output logic [scanint_pkg::COL_W-1:0]   ram_addr,
	output logic [scanint_pkg::COLOR_W-1:0] ram_wdata
);
	import scanint_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_cur;
	logic [ROW_W-1:0] row_cur;
	logic [COL_W-1:0] col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic             accept;

	assign pix.ready = !valid_s1 || take;
	assign accept    = pix.valid && pix.ready;

	always_comb begin
		col_cur = pix.frame_start ? '0 : col_q;
		row_cur = pix.frame_start ? '0 : row_q;
		col_nxt = col_cur + 1'b1;
		row_nxt = row_cur;
		if (col_cur == COL_W'(LINE_WIDTH - 1)) begin
			col_nxt = '0;
			row_nxt = (row_cur == ROW_W'(SRC_ROWS - 1)) ? '0 : row_cur + 1'b1;
		end
	end

	// pixel above is read and the new pixel written in the same cycle
	assign ram_we    = accept;
	assign ram_re    = accept;
	assign ram_addr  = col_cur;
	assign ram_wdata = pix.color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				col_q    <= col_nxt;
				row_q    <= row_nxt;
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.col   <= col_cur;
			item_s1.row   <= row_cur;
			item_s1.color <= pix.color;
		end
	end

endmodule

FILE: hdl/scanint_emit.sv
// Result sequencer: issues the one to three words of the stage 1 item into the output register.
// Depends on scanint_pkg and scanint_if.
module scanint_emit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  scanint_pkg::item_t               item_s1,
	input  logic [scanint_pkg::COLOR_W-1:0]  above,
	input  logic [scanint_pkg::ALPHA_W-1:0]  alpha,
	output logic                             take,
	scanint_res_if.source                    res
);
	import scanint_pkg::*;

	phase_t     phase_q;
	phase_t     phase_nxt;
	res_kind_t  kind;
	logic       has_interp;
	logic       final_row;
	logic       is_last;
	logic       load;
	logic [ROW_W:0]       dbl_row;
	logic [ROW_W:0]       dbl_row_m1;
	logic [COORD_W-1:0]   row_w;
	logic [ARGB_W-1:0]    argb_w;
	logic [COLOR_W-1:0]   avg;
	logic                 out_valid_q;
	logic [COORD_W-1:0]   out_row_q;
	logic [COORD_W-1:0]   out_col_q;
	logic [ARGB_W-1:0]    argb_q;
	logic                 last_q;

	function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	assign has_interp = item_s1.row != '0;
	assign final_row  = item_s1.row == ROW_W'(SRC_ROWS - 1);
	assign load       = valid_s1 && (!out_valid_q || res.ready);

	always_comb begin
		case (phase_q)
			PH_FIRST:  kind = has_interp ? RK_INTERP : RK_SOURCE;
			PH_SOURCE: kind = RK_SOURCE;
			PH_FINAL:  kind = RK_FINAL;
			default:   kind = RK_SOURCE;
		endcase
		is_last = (kind == RK_FINAL) || (kind == RK_SOURCE && !final_row);
		take    = load && is_last;
	end

	// next state
	always_comb begin
		phase_nxt = phase_q;
		if (load) begin
			if (is_last) begin
				phase_nxt = PH_FIRST;
			end else begin
				case (kind)
					RK_INTERP: phase_nxt = PH_SOURCE;
					RK_SOURCE: phase_nxt = PH_FINAL;
					default:   phase_nxt = PH_FIRST;
				endcase
			end
		end
	end

	// word contents
	always_comb begin
		dbl_row    = {item_s1.row, 1'b0};
		dbl_row_m1 = dbl_row - 1'b1;
		avg = {avg8(above[23:16], item_s1.color[23:16]),
		       avg8(above[15:8],  item_s1.color[15:8]),
		       avg8(above[7:0],   item_s1.color[7:0])};
		case (kind)
			RK_INTERP: begin
				row_w  = COORD_W'(dbl_row_m1);
				argb_w = {alpha, avg};
			end
			RK_SOURCE: begin
				row_w  = COORD_W'(dbl_row);
				argb_w = {ALPHA_OPAQUE, item_s1.color};
			end
			RK_FINAL: begin
				row_w  = COORD_W'(FRAME_ROWS - 1);
				argb_w = {alpha, item_s1.color};
			end
			default: begin
				row_w  = COORD_W'(dbl_row);
				argb_w = {ALPHA_OPAQUE, item_s1.color};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_row_q <= row_w;
			out_col_q <= COORD_W'(item_s1.col);
			argb_q    <= argb_w;
			last_q    <= is_last;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.out_row = out_row_q;
	assign res.out_col = out_col_q;
	assign res.argb    = argb_q;
	assign res.last    = last_q;

endmodule

FILE: hdl/scanline_interpolator_top.sv
// Scanline interpolator: line doubler filling odd rows with the average of the rows around them
// and the bottom row with a copy of the final source row; pixels register in stage 1, words in
// the output register. Throughput: one result word per cycle while the receiver is ready; a pixel
//   causes one word on the first source row, two on most rows and three on the final source row,
//   and the next pixel is taken in the cycle its final word issues.
// Reset: counters cleared, scanline alpha to 0xb0, pipeline emptied; line buffer not cleared.
module scanline_interpolator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [scanint_pkg::ALPHA_W-1:0] cfg_wdata,
	scanint_pix_if.sink                     pix,
	scanint_res_if.source                   res
);
	import scanint_pkg::*;

	logic [ALPHA_W-1:0] alpha_q;

	// stage 1: item register in the front, line buffer data in the RAM output register
	logic               valid_s1;
	item_t              item_s1;
	logic               take;
	logic               ram_we;
	logic               ram_re;
	logic [COL_W-1:0]   ram_addr;
	logic [COLOR_W-1:0] ram_wdata;
	logic [COLOR_W-1:0] above;

	// scanline alpha register; the user must write it only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	// counters and line buffer addressing; a new pixel is taken while stage 1 is empty or in the
	// cycle the previous one issues its final result word
	scanint_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.take      (take),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata)
	);

	// one line of source pixels; the read data only moves on a new pixel,
	// so it holds the pixel above for as long as the item sits in stage 1
	scanint_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (LINE_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (above)
	);

	// interpolated, source and final row words, one per cycle while the receiver is ready
	scanint_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.above    (above),
		.alpha    (alpha_q),
		.take     (take),
		.res      (res)
	);

	logic [COL_W-1:0] col_succ;
	assign col_succ = (item_s1.col == COL_W'(LINE_WIDTH - 1)) ? '0 : item_s1.col + 1'b1;

`ifndef NO_ASSERTIONS
	// a word that is not the final one leaves its item waiting in stage 1
	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.last |-> valid_s1)
		else $error("non-final word shown with stage 1 empty");

	// releasing an item puts its final word in the output register
	a_take_last: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res.valid && res.last)
		else $error("item released without a final word");

	// consecutive pixels without frame start walk the columns in order
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready && valid_s1 && !pix.frame_start
		|=> item_s1.col == $past(col_succ))
		else $error("column counter out of sequence");
`endif

endmodule

FILE: tb/tb_scanline_interpolator_top.sv
// Self-checking testbench for scanline_interpolator_top: pixel words in, ARGB words out.
// Needs scanint_pkg and the scanint_pix_if / scanint_res_if interfaces from hdl.
// Expected words are predicted per accepted pixel and checked in order at the output.
module tb_scanline_interpolator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import scanint_pkg::*;

	// One expected output word: row, column, pixel, end-of-pixel flag
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [ARGB_W-1:0]  argb;
		logic               last;
	} pix_word_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [ALPHA_W-1:0] cfg_wdata;

	scanint_pix_if pix_ch ();
	scanint_res_if res_ch ();

	scanline_interpolator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_ch),
		.res       (res_ch)
	);

	// Predictor state: own copy of the line buffer, counters and alpha register
	logic [COLOR_W-1:0] line_copy [LINE_WIDTH];
	int                 col_cnt;
	int                 row_cnt;
	logic [ALPHA_W-1:0] scan_alpha;

	pix_word_t expected_words [$];
	int        mismatch_count;
	int        tx_idle_pct;
	int        rx_idle_pct;

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Every input known from time zero
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		pix_ch.valid      = 1'b0;
		pix_ch.frame_start = 1'b0;
		pix_ch.color      = '0;
		res_ch.ready      = 1'b0;
		tx_idle_pct       = 0;
		rx_idle_pct       = 0;
		mismatch_count    = 0;
	end

	// Receiver back-pressure, redrawn every falling edge
	always @(negedge clk)
		res_ch.ready = ($urandom_range(99) >= rx_idle_pct);

	task automatic report_mismatch(input string what, input logic [ARGB_W-1:0] got,
			input logic [ARGB_W-1:0] want);
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Average of two RGB words, channel by channel, rounding down
	function automatic logic [COLOR_W-1:0] mix_rgb(input logic [COLOR_W-1:0] a,
			input logic [COLOR_W-1:0] b);
		logic [8:0] r, g, bl;
		r  = {1'b0, a[23:16]} + {1'b0, b[23:16]};
		g  = {1'b0, a[15:8]}  + {1'b0, b[15:8]};
		bl = {1'b0, a[7:0]}   + {1'b0, b[7:0]};
		return {r[8:1], g[8:1], bl[8:1]};
	endfunction

	// Works out the output words of one accepted pixel and advances the counters
	task automatic predict_pixel(input logic fs, input logic [COLOR_W-1:0] color);
		pix_word_t w;
		if (fs) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		// Odd row above, from the second source row on
		if (row_cnt >= 1) begin
			w.row  = COORD_W'(2 * row_cnt - 1);
			w.col  = COORD_W'(col_cnt);
			w.argb = {scan_alpha, mix_rgb(line_copy[col_cnt], color)};
			w.last = 1'b0;
			expected_words.push_back(w);
		end
		// The pixel itself, opaque, on its even row
		w.row  = COORD_W'(2 * row_cnt);
		w.col  = COORD_W'(col_cnt);
		w.argb = {ALPHA_OPAQUE, color};
		w.last = (row_cnt != SRC_ROWS - 1);
		expected_words.push_back(w);
		// Final source row repeats onto the bottom output row
		if (row_cnt == SRC_ROWS - 1) begin
			w.row  = COORD_W'(FRAME_ROWS - 1);
			w.argb = {scan_alpha, color};
			w.last = 1'b1;
			expected_words.push_back(w);
		end
		line_copy[col_cnt] = color;
		col_cnt++;
		if (col_cnt >= LINE_WIDTH) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= SRC_ROWS)
				row_cnt = 0;
		end
	endtask

	// Output checker: each accepted word against the oldest expectation
	always @(posedge clk) begin
		pix_word_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word, argb", res_ch.argb, '0);
			end else begin
				w = expected_words.pop_front();
				if (res_ch.out_row !== w.row)
					report_mismatch("out_row", res_ch.out_row, w.row);
				if (res_ch.out_col !== w.col)
					report_mismatch("out_col", res_ch.out_col, w.col);
				if (res_ch.argb !== w.argb)
					report_mismatch("argb", res_ch.argb, w.argb);
				if (res_ch.last !== w.last)
					report_mismatch("last", res_ch.last, w.last);
			end
		end
	end

	// Sends one pixel word, with random sender gaps, and predicts once it is taken
	task automatic send_pixel(input logic fs, input logic [COLOR_W-1:0] color);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			pix_ch.valid = 1'b0;
		end
		@(negedge clk);
		pix_ch.valid       = 1'b1;
		pix_ch.frame_start = fs;
		pix_ch.color       = color;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		predict_pixel(fs, color);
	endtask

	// Sender stops and waits until every expected word has come out
	task automatic drain_block();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Alpha register write, only with the block idle
	task automatic write_alpha(input logic [ALPHA_W-1:0] value);
		drain_block();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		scan_alpha = value;
	endtask

	// Mostly random colours, with black and white thrown in often
	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(7))
			0:       return 24'h000000;
			1:       return 24'hffffff;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	// Counters start at row 0, column 0 after reset without any frame start;
	// the first four colours become the row above in the line wrap test
	task automatic test_reset_state();
		logic [COLOR_W-1:0] colors [6];
		colors = '{24'h000000, 24'hffffff, 24'h800000, 24'h00ff00, 24'h0000ff, 24'h123456};
		foreach (colors[i])
			send_pixel(1'b0, colors[i]);
	endtask

	// Random colours carrying on from wherever the counters are, no frame start
	task automatic test_row_fill(input int n_items);
		for (int i = 0; i < n_items; i++)
			send_pixel(1'b0, pick_color());
	endtask

	// Row 1 after the wrap: known colours below the row 0 ones, reset alpha on odd rows
	task automatic test_line_wrap();
		logic [COLOR_W-1:0] lower [4];
		lower = '{24'hffffff, 24'hffffff, 24'h00ff00, 24'h000000};
		for (int c = 0; c < 8; c++)
			send_pixel(1'b0, (c < 4) ? lower[c] : pick_color());
	endtask

	// Frame start in mid-row pulls the counters back to the origin
	task automatic test_frame_restart();
		send_pixel(1'b1, 24'ha5a5a5);
		send_pixel(1'b0, 24'h5a5a5a);
		send_pixel(1'b1, 24'hfe0102);
	endtask

	// Main sequence
	initial begin
		foreach (line_copy[i])
			line_copy[i] = '0;
		col_cnt    = 0;
		row_cnt    = 0;
		scan_alpha = ALPHA_RESET;

		// Reset held from time zero, released on a falling edge
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Sender mostly busy, receiver mostly stalled
		tx_idle_pct = 18;
		rx_idle_pct = 66;
		test_reset_state();
		test_row_fill(150);

		// Sender mostly idle, receiver mostly ready; row 0 completes here
		drain_block();
		tx_idle_pct = 66;
		rx_idle_pct = 18;
		test_row_fill(LINE_WIDTH - 156);
		test_line_wrap();

		// Full rate both ways, two words per pixel on row 1
		write_alpha(ALPHA_W'($urandom_range(255)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_row_fill(12);
		test_frame_restart();

		drain_block();
		repeat (8) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch("words never produced", expected_words.size(), 0);
		if (mismatch_count == 0)
			$display("scanline_interpolator_top verification clean");
		else
			$display("scanline_interpolator_top verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("scanline_interpolator_top verification failed");
		$finish;
	end

endmodule
